// File: hw/rtl/bbm_pkg.sv
// Shared constants and types for the binary boundary marker.
`default_nettype none
package bbm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;

  localparam int CFG_NUM   = 2;
  localparam int CFG_IDX_W = $clog2(CFG_NUM);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [COL_W-1:0] WIDTH_M1_RST  = COL_W'(640 - 1);
  localparam logic [ROW_W-1:0] HEIGHT_M1_RST = ROW_W'(480 - 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  // One column of the two line stores: pixel two rows up and one row up.
  typedef struct packed {
    logic up;
    logic ctr;
  } line_t;

  typedef struct packed {
    logic edge_bit;
    logic frame_last;
  } res_t;

  // Up to two results per accepted pixel, in emission order.
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      item;
  } q_push_t;

endpackage
`default_nettype wire

// File: hw/rtl/bbm_if.sv
// Pixel and result channel interfaces.
`default_nettype none
interface bbm_pix_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bbm_res_if;
  logic valid;
  logic ready;
  logic edge_bit;
  logic frame_last;

  modport source (output valid, output edge_bit, output frame_last, input ready);
  modport sink   (input valid, input edge_bit, input frame_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/binary_boundary_marker.sv
// Top level: streaming 4-neighbor boundary marker for binary images.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------
//  pix     | in  | valid/ready        | pixel_in (1b)
//  res     | out | valid/ready        | edge_bit (1b), frame_last (1b)
//  cfg     | in  | cfg_we, no stall   | cfg_index (1b), cfg_data (11b)
//
//  One pixel per cycle while the queue has room; results leave through a 4-item
//  queue, one per cycle while res is ready. In the last row a pixel gives
//  two results (one in a one-row frame), so the single output port stalls pix.
//  Line stores: one 2-bit x MAX_WIDTH RAM, read two columns ahead, one item
//  before first use.
//  Reset: synchronous; counters and queue pointers clear, sizes go to
//  640 x 480, RAM holds.
//  A stalled output only blocks pix once the queue has fewer than 2 free slots.
`default_nettype none
module binary_boundary_marker import bbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  bbm_pix_if.sink              pix,
  bbm_res_if.source            res
);

  // Clamped sizes, stored minus one.
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // Window registers. cur holds the store column for the current pixel,
  // the RAM read register holds the column to its right (read one item
  // earlier), prev_ctr is the center of the column to the left.
  line_t            cur;
  line_t            rd_line;
  logic [1:0]       rd_raw;
  logic             prev_ctr;
  logic             hist0;
  logic             hist1;

  logic             accept;
  logic             room;
  logic             narrow;
  logic             ctr;
  logic [4:0]       five;
  logic             boundary;
  logic             e;
  logic             last_row;
  logic             col_last;
  logic [COL_W:0]   ahead;
  logic [COL_W:0]   w_full;
  logic [COL_W-1:0] rd_addr;
  line_t            wr_line;
  q_push_t          push;

  assign pix.ready = room;
  assign accept    = pix.valid & pix.ready;

  assign last_row = row == h_m1;
  assign col_last = col == w_m1;

  // Widths below 3 have no interior; the center pixel is then simply the
  // one w items back, kept in a two-deep history.
  assign narrow = w_m1 < COL_W'(2);
  assign ctr    = narrow ? ((w_m1 == '0) ? hist0 : hist1) : cur.ctr;

  assign rd_line  = line_t'(rd_raw);
  assign five     = {ctr, cur.up, prev_ctr, rd_line.ctr, pix.pixel_in};
  assign boundary = (|five) & ~(&five);
  assign e        = (row == ROW_W'(1) || col == '0 || col_last) ? ctr : boundary;

  // Prefetch address: two columns ahead, wrapping into the next row.
  assign w_full  = {1'b0, w_m1} + (COL_W+1)'(1);
  assign ahead   = {1'b0, col} + (COL_W+1)'(2);
  assign rd_addr = (ahead >= w_full) ? COL_W'(ahead - w_full) : ahead[COL_W-1:0];

  assign wr_line.up  = cur.ctr;
  assign wr_line.ctr = pix.pixel_in;

  always_comb begin
    push.n = 2'd0;
    push.item[0].edge_bit   = pix.pixel_in;
    push.item[0].frame_last = col_last;
    push.item[1].edge_bit   = pix.pixel_in;
    push.item[1].frame_last = col_last;
    if (row != '0) begin
      push.item[0].edge_bit   = e;
      push.item[0].frame_last = 1'b0;
    end
    if (accept) begin
      push.n = 2'(row != '0) + 2'(last_row);
    end
  end

  bbm_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (wr_line),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  bbm_out_queue u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

  // Window payload, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= rd_line;
      prev_ctr <= cur.ctr;
      hist1    <= hist0;
      hist0    <= pix.pixel_in;
    end
  end

  // Sizes and raster position; any size write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= WIDTH_M1_RST;
      h_m1 <= HEIGHT_M1_RST;
      col  <= '0;
      row  <= '0;
    end else if (cfg_we) begin
      col <= '0;
      row <= '0;
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data == '0) begin
            w_m1 <= '0;
          end else if (cfg_data > SIZE_W'(MAX_WIDTH)) begin
            w_m1 <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_m1 <= COL_W'(cfg_data - SIZE_W'(1));
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) begin
            h_m1 <= '0;
          end else if (cfg_data > SIZE_W'(MAX_HEIGHT)) begin
            h_m1 <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_m1 <= ROW_W'(cfg_data - SIZE_W'(1));
          end
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  a_double_only_last_row: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> last_row)
    else $error("two results outside the last row");

  a_position_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= w_m1) && (row <= h_m1))
    else $error("raster position outside frame");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (col == '0 && row == '0))
    else $error("size write did not restart frame");

endmodule
`default_nettype wire

// File: hw/rtl/bbm_ram.sv
// Generic simple dual-port RAM, registered read.
`default_nettype none
module bbm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bbm_out_queue.sv
// Result queue: takes up to two items per cycle, sends one while res is ready.
`default_nettype none
module bbm_out_queue import bbm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  q_push_t       push,
  output logic          room,
  bbm_res_if.source     res
);

  res_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_PTR_W:0]   count;
  logic                pop;

  assign pop   = res.valid & res.ready;
  assign room  = count <= (OQ_PTR_W+1)'(OQ_DEPTH - 2);

  assign res.valid      = count != '0;
  assign res.edge_bit   = mem[rd_ptr].edge_bit;
  assign res.frame_last = mem[rd_ptr].frame_last;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.item[0];
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= push.item[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.n);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + (OQ_PTR_W+1)'(push.n) - (OQ_PTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (OQ_PTR_W+1)'(OQ_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("push into result queue without room");

endmodule
`default_nettype wire
